// ===== hw/rtl/nts_pkg.sv =====
// Shared types, widths and defaults for the NKRO to six-slot report converter.
package nts_pkg;

    // Fixed field widths.
    localparam int KEY_W        = 8;
    localparam int WORD_W       = 64;
    localparam int WORD_COUNT   = 4;
    localparam int FULL_MAP_W   = WORD_W * WORD_COUNT;
    localparam int SLOT_FIELDS  = 6;
    localparam int SLOT_SEL_W   = 3;

    // Default configuration of the converter.
    localparam int SLOT_COUNT_DEF     = 6;
    localparam int BITMAP_BYTES_DEF   = 32;
    localparam int OVERFLOW_BYTES_DEF = 32;

    // Command from the sequencer to the slot unit.
    typedef struct packed {
        logic                  clear;
        logic                  probe;
        logic                  free;
        logic [KEY_W-1:0]      usage;
        logic [SLOT_SEL_W-1:0] idx;
    } slot_cmd_t;

    // Status from the slot unit back to the sequencer.
    typedef struct packed {
        logic             no_room;
        logic [KEY_W-1:0] rd_key;
    } slot_stat_t;

endpackage

// ===== hw/rtl/nts_slots.sv =====
// Persistent key slots with a shared match and first-empty compare unit.
module nts_slots
    import nts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  slot_cmd_t                          cmd,
    output slot_stat_t                         stat,
    output logic [SLOT_COUNT-1:0][KEY_W-1:0]   slots
);

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_reg;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_next;
    logic                             match;
    logic                             any_empty;
    logic [SLOT_IDX_W-1:0]            first_idx;

    // Compare the probed usage against every slot and find the first empty one.
    always_comb
    begin
        match     = 1'b0;
        any_empty = 1'b0;
        first_idx = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--)
        begin
            if (slot_reg[k] == cmd.usage)
            begin
                match = 1'b1;
            end
            if (slot_reg[k] == '0)
            begin
                any_empty = 1'b1;
                first_idx = SLOT_IDX_W'(k);
            end
        end
    end

    assign stat.no_room = !match && !any_empty;
    assign stat.rd_key  = slot_reg[cmd.idx[SLOT_IDX_W-1:0]];
    assign slots        = slot_reg;

    // Slot update: clear, fill on a missed probe, or release.
    always_comb
    begin
        slot_next = slot_reg;
        priority if (cmd.clear)
        begin
            slot_next = '0;
        end
        else if (cmd.probe && !match && any_empty)
        begin
            slot_next[first_idx] = cmd.usage;
        end
        else if (cmd.free)
        begin
            slot_next[cmd.idx[SLOT_IDX_W-1:0]] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    // A clear empties every slot on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (slot_reg == '0))
        else $error("slots not empty after clear");

    // The sequencer never probes and releases in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.probe && cmd.free))
        else $error("probe and release overlap");

endmodule

// ===== hw/rtl/nts_ctrl.sv =====
// Sequencer: walks the bitmap byte by byte, drives the slot unit, builds the result.
module nts_ctrl
    import nts_pkg::*;
#(
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int BITMAP_BYTES   = BITMAP_BYTES_DEF,
    parameter int OVERFLOW_BYTES = OVERFLOW_BYTES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               clear_all,
    input  logic [KEY_W-1:0]                   modifier_bits,
    input  logic [FULL_MAP_W-1:0]              map_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [KEY_W-1:0]                   out_mods,
    output logic [SLOT_COUNT-1:0][KEY_W-1:0]   out_slots,
    output logic [OVERFLOW_BYTES*8-1:0]        out_ovf,
    output slot_cmd_t                          cmd,
    input  slot_stat_t                         stat,
    input  logic [SLOT_COUNT-1:0][KEY_W-1:0]   slots
);

    localparam int MAP_BITS   = BITMAP_BYTES * 8;
    localparam int OVF_BITS   = OVERFLOW_BYTES * 8;
    localparam int MAP_IDX_W  = $clog2(MAP_BITS);
    localparam int OVF_IDX_W  = $clog2(OVF_BITS);
    localparam int BYTE_W     = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_REL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [MAP_BITS-1:0]              map_reg, map_next;
    logic [7:0]                       byte_reg, byte_next;
    logic [BYTE_W-1:0]                bidx_reg, bidx_next;
    logic [SLOT_IDX_W-1:0]            sidx_reg, sidx_next;
    logic [KEY_W-1:0]                 mods_reg, mods_next;
    logic [OVF_BITS-1:0]              ovf_reg, ovf_next;
    logic                             out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]                 out_mods_reg, out_mods_next;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] out_slots_reg, out_slots_next;
    logic [OVF_BITS-1:0]              out_ovf_reg, out_ovf_next;
    logic [2:0]                       top_bit;
    logic [KEY_W-1:0]                 usage;
    logic                             pressed;
    logic                             accept;
    logic                             out_free;

    // Highest set bit of a byte.
    function automatic logic [2:0] hi_bit(input logic [7:0] b);
        logic [2:0] r;
        r = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (b[j])
            begin
                r = 3'(j);
            end
        end
        return r;
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign top_bit  = hi_bit(byte_reg);
    assign usage    = {5'(bidx_reg), top_bit};

    // Bitmap lookup for the key held in the slot under release check.
    assign pressed = (9'(stat.rd_key) < 9'(MAP_BITS)) && map_reg[stat.rd_key[MAP_IDX_W-1:0]];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        map_next       = map_reg;
        byte_next      = byte_reg;
        bidx_next      = bidx_reg;
        sidx_next      = sidx_reg;
        mods_next      = mods_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_mods_next  = out_mods_reg;
        out_slots_next = out_slots_reg;
        out_ovf_next   = out_ovf_reg;
        cmd            = '0;
        cmd.usage      = usage;
        cmd.idx        = SLOT_SEL_W'(sidx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    map_next  = map_in[MAP_BITS-1:0];
                    byte_next = clear_all ? 8'h00 : map_in[7:0];
                    bidx_next = '0;
                    sidx_next = '0;
                    mods_next = clear_all ? 8'h00 : modifier_bits;
                    ovf_next  = '0;
                    cmd.clear = clear_all;
                    state_next = clear_all ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (byte_reg == 8'h00)
                begin
                    if (bidx_reg == BYTE_W'(BITMAP_BYTES - 1))
                    begin
                        sidx_next  = '0;
                        state_next = S_REL;
                    end
                    else
                    begin
                        bidx_next = bidx_reg + 1'b1;
                        byte_next = map_reg[{bidx_next, 3'b000} +: 8];
                    end
                end
                else
                begin
                    cmd.probe = 1'b1;
                    if (stat.no_room && (9'(usage) < 9'(OVF_BITS)))
                    begin
                        ovf_next[usage[OVF_IDX_W-1:0]] = 1'b1;
                    end
                    byte_next[top_bit] = 1'b0;
                end
            end
            S_REL:
            begin
                cmd.free = (stat.rd_key != '0) && !pressed;
                if (sidx_reg == SLOT_IDX_W'(SLOT_COUNT - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mods_next  = mods_reg;
                    out_slots_next = slots;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        map_reg       <= map_next;
        byte_reg      <= byte_next;
        bidx_reg      <= bidx_next;
        sidx_reg      <= sidx_next;
        mods_reg      <= mods_next;
        ovf_reg       <= ovf_next;
        out_mods_reg  <= out_mods_next;
        out_slots_reg <= out_slots_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid = out_valid_reg;
    assign out_mods  = out_mods_reg;
    assign out_slots = out_slots_reg;
    assign out_ovf   = out_ovf_reg;

    // A clear request skips the walk and goes straight to the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && clear_all) |=> (state_reg == S_FIN))
        else $error("clear request did not skip the walk");

    // Each scan step on a nonzero byte retires exactly one pressed bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && byte_reg != 8'h00)
            |=> ($countones(byte_reg) == $countones($past(byte_reg)) - 1))
        else $error("scan step did not retire one bit");

    // A pending result is never overwritten while the sink stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_slots_reg)))
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/nkro_to_six_slot_report_top.sv =====
// Top level of the NKRO to six-slot report converter.
// From accept, the sequencer walks the bitmap byte by byte, probes the shared slot compare unit
// for each pressed key, checks every slot for release and then registers the result; a clear request skips the walk.
// One transaction at a time: in_stall is high from accept until the result is registered,
// and the next transaction is taken while that result waits on out_stall.
// Reset (rst_n low, asynchronous) empties all slots and drops any pending result.
module nkro_to_six_slot_report_top
    import nts_pkg::*;
#(
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int BITMAP_BYTES   = BITMAP_BYTES_DEF,
    parameter int OVERFLOW_BYTES = OVERFLOW_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              clear_all,
    input  logic [KEY_W-1:0]  modifier_bits,
    input  logic [WORD_W-1:0] keymap_word0,
    input  logic [WORD_W-1:0] keymap_word1,
    input  logic [WORD_W-1:0] keymap_word2,
    input  logic [WORD_W-1:0] keymap_word3,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KEY_W-1:0]  out_modifiers,
    output logic [KEY_W-1:0]  slot_key0,
    output logic [KEY_W-1:0]  slot_key1,
    output logic [KEY_W-1:0]  slot_key2,
    output logic [KEY_W-1:0]  slot_key3,
    output logic [KEY_W-1:0]  slot_key4,
    output logic [KEY_W-1:0]  slot_key5,
    output logic [WORD_W-1:0] overflow_word0,
    output logic [WORD_W-1:0] overflow_word1,
    output logic [WORD_W-1:0] overflow_word2,
    output logic [WORD_W-1:0] overflow_word3
);

    slot_cmd_t                        cmd;
    slot_stat_t                       stat;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] slots;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] out_slots;
    logic [OVERFLOW_BYTES*8-1:0]      out_ovf;
    logic [FULL_MAP_W-1:0]            ovf_full;
    logic [FULL_MAP_W-1:0]            map_in;
    logic [SLOT_FIELDS-1:0][KEY_W-1:0] slot_arr;

    assign map_in = {keymap_word3, keymap_word2, keymap_word1, keymap_word0};

    nts_ctrl #(
        .SLOT_COUNT     (SLOT_COUNT),
        .BITMAP_BYTES   (BITMAP_BYTES),
        .OVERFLOW_BYTES (OVERFLOW_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .clear_all     (clear_all),
        .modifier_bits (modifier_bits),
        .map_in        (map_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_mods      (out_modifiers),
        .out_slots     (out_slots),
        .out_ovf       (out_ovf),
        .cmd           (cmd),
        .stat          (stat),
        .slots         (slots)
    );

    nts_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .slots (slots)
    );

    // Slots beyond the configured count read as empty.
    for (genvar k = 0; k < SLOT_FIELDS; k++)
    begin : g_slot
        if (k < SLOT_COUNT)
        begin : g_used
            assign slot_arr[k] = out_slots[k];
        end
        else
        begin : g_unused
            assign slot_arr[k] = '0;
        end
    end

    assign slot_key0 = slot_arr[0];
    assign slot_key1 = slot_arr[1];
    assign slot_key2 = slot_arr[2];
    assign slot_key3 = slot_arr[3];
    assign slot_key4 = slot_arr[4];
    assign slot_key5 = slot_arr[5];

    // Overflow bits beyond the overflow length read as zero.
    assign ovf_full       = FULL_MAP_W'(out_ovf);
    assign overflow_word0 = ovf_full[WORD_W-1:0];
    assign overflow_word1 = ovf_full[2*WORD_W-1:WORD_W];
    assign overflow_word2 = ovf_full[3*WORD_W-1:2*WORD_W];
    assign overflow_word3 = ovf_full[4*WORD_W-1:3*WORD_W];

endmodule
